// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL files; only the median core includes them.
// Each expects clk and rst_n in scope; checks are off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define SWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/swm_pkg.sv =====
package swm_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WINDOW_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // Span register: 5 bits, so at most 31
  localparam int              SPAN_W     = 5;
  localparam int              SPAN_MAX   = 31;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 5'd4;

  // Flags a cell hands to its right-hand neighbor
  typedef struct packed {
    logic lt;   // cell holds a valid value below the new sample
    logic brm;  // removal slot lies at or left of this cell
  } link_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic              en;      // a sample beat updates the row
    logic              full;    // this beat also drops the oldest entry
    logic [SPAN_W-1:0] rm_age;  // age of the entry that leaves
    logic [SPAN_W-1:0] fill;    // number of valid cells before the beat
  } cell_ctl_t;

endpackage

// ===== src/swm_cell.sv =====
module swm_cell #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  parameter int CELL_IDX    = 0
) (
  input  logic                          clk,
  input  swm_pkg::cell_ctl_t            ctl,
  input  logic signed [SAMPLE_BITS-1:0] new_val,
  input  swm_pkg::link_t                left_lnk,
  input  logic signed [SAMPLE_BITS-1:0] left_val,
  input  logic [swm_pkg::SPAN_W-1:0]    left_age,
  input  logic                          right_lt,
  input  logic signed [SAMPLE_BITS-1:0] right_val,
  input  logic [swm_pkg::SPAN_W-1:0]    right_age,
  output swm_pkg::link_t                lnk_out,
  output logic signed [SAMPLE_BITS-1:0] val_out,
  output logic [swm_pkg::SPAN_W-1:0]    age_out,
  output logic signed [SAMPLE_BITS-1:0] ins_val
);

  logic signed [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic [swm_pkg::SPAN_W-1:0]    age_r, age_nxt;
  logic                          valid;
  logic                          lt;
  logic                          rm;
  logic                          brm;

  // Local compare and removal match
  assign valid = int'(ctl.fill) > CELL_IDX;
  assign lt    = valid && (val_r < new_val);
  assign rm    = ctl.full && valid && (age_r == ctl.rm_age);
  assign brm   = left_lnk.brm | rm;

  assign lnk_out = '{lt: lt, brm: brm};
  assign val_out = val_r;
  assign age_out = age_r;

  // Sorted row right after insertion, before the oldest leaves
  assign ins_val = lt ? val_r : (left_lnk.lt ? new_val : left_val);

  // Insert and remove in one step: shift left past the hole or right past the sample
  always_comb begin
    if (lt) begin
      if (!brm) begin
        val_nxt = val_r;
        age_nxt = age_r + 1'b1;
      end else if (right_lt) begin
        val_nxt = right_val;
        age_nxt = right_age + 1'b1;
      end else begin
        val_nxt = new_val;
        age_nxt = '0;
      end
    end else begin
      if (left_lnk.brm) begin
        val_nxt = val_r;
        age_nxt = age_r + 1'b1;
      end else if (left_lnk.lt) begin
        val_nxt = new_val;
        age_nxt = '0;
      end else begin
        val_nxt = left_val;
        age_nxt = left_age + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

endmodule

// ===== src/sliding_window_median_core.sv =====
// The median of an accepted sample beat is registered and then shows on out_median.
// One sample per cycle unless in_stall holds; each nonzero-span beat rewrites the row.
// The first span samples after reset or a span write give no result.
// Reset (rst_n low, synchronous): window empty, span 4, no result pending.
// Cell contents are not reset; only cells below the fill count are ever used.
`include "assert_macros.svh"

module sliding_window_median_core #(
  parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [swm_pkg::SPAN_W-1:0]    cfg_window_span,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_median
);

  localparam int SPAN_W   = swm_pkg::SPAN_W;
  localparam int IDX_W    = $clog2(MAX_WINDOW);
  localparam int SPAN_CAP = (MAX_WINDOW - 1 > swm_pkg::SPAN_MAX) ?
                            swm_pkg::SPAN_MAX : MAX_WINDOW - 1;

  logic [SPAN_W-1:0]             span_r, span_nxt;
  logic [SPAN_W-1:0]             fill_r, fill_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_median_r;

  logic [SPAN_W-1:0]             eff_span;
  logic                          span_zero;
  logic                          full;
  logic                          produce;
  logic                          in_accept;
  logic [IDX_W-1:0]              mid_idx;
  logic signed [SAMPLE_BITS-1:0] median_val;
  swm_pkg::cell_ctl_t            ctl;

  logic signed [SAMPLE_BITS-1:0] val_w [MAX_WINDOW];
  logic [SPAN_W-1:0]             age_w [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] ins_w [MAX_WINDOW];
  swm_pkg::link_t                lnk_w [MAX_WINDOW];

  // Span saturates at one below the row length, or at SPAN_MAX if that is smaller
  assign eff_span  = (int'(span_r) > SPAN_CAP) ? SPAN_W'(SPAN_CAP) : span_r;
  assign span_zero = (eff_span == '0);
  assign full      = !span_zero && (fill_r == eff_span);
  assign produce   = span_zero || full;
  assign mid_idx   = IDX_W'(eff_span >> 1);

  // Handshake: take a beat unless a result is waiting and stalled
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Broadcast control
  assign ctl.en     = in_accept && !span_zero;
  assign ctl.full   = full;
  assign ctl.rm_age = eff_span - 1'b1;
  assign ctl.fill   = fill_r;

  // Row of sorted cells
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_pkg::link_t                left_lnk;
    logic signed [SAMPLE_BITS-1:0] left_val;
    logic [SPAN_W-1:0]             left_age;
    logic                          right_lt;
    logic signed [SAMPLE_BITS-1:0] right_val;
    logic [SPAN_W-1:0]             right_age;

    if (i == 0) begin : g_left_edge
      assign left_lnk = '{lt: 1'b1, brm: 1'b0};
      assign left_val = in_sample;
      assign left_age = '0;
    end else begin : g_left_link
      assign left_lnk = lnk_w[i-1];
      assign left_val = val_w[i-1];
      assign left_age = age_w[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_right_edge
      assign right_lt  = 1'b0;
      assign right_val = in_sample;
      assign right_age = '0;
    end else begin : g_right_link
      assign right_lt  = lnk_w[i+1].lt;
      assign right_val = val_w[i+1];
      assign right_age = age_w[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CELL_IDX    (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_val   (in_sample),
      .left_lnk  (left_lnk),
      .left_val  (left_val),
      .left_age  (left_age),
      .right_lt  (right_lt),
      .right_val (right_val),
      .right_age (right_age),
      .lnk_out   (lnk_w[i]),
      .val_out   (val_w[i]),
      .age_out   (age_w[i]),
      .ins_val   (ins_w[i])
    );
  end

  // Median pick from the post-insert row, or the new sample itself at span zero
  assign median_val = span_zero ? in_sample : ins_w[mid_idx];

  // Span and fill count
  always_comb begin
    span_nxt = span_r;
    fill_nxt = fill_r;
    if (cfg_we) begin
      span_nxt = cfg_window_span;
      fill_nxt = '0;
    end else if (in_accept && !produce) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  // Output register
  always_comb begin
    if (in_accept && produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r      <= swm_pkg::SPAN_RESET;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      span_r      <= span_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && produce) begin
      out_median_r <= median_val;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

  // Checks
  `SWM_ASSERT_ALWAYS(a_fill_in_range, fill_r <= eff_span, "fill count beyond span")
  `SWM_ASSERT_NEXT(a_result_from_beat, !out_valid_r && !(in_accept && produce), !out_valid_r, "result without a beat")
  `SWM_ASSERT_NEXT(a_fill_grows, in_accept && !produce && !cfg_we, fill_r == $past(fill_r) + 1'b1, "fill did not advance")

endmodule

// ===== verif/tb_sliding_window_median_core.sv =====
module tb_sliding_window_median_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W = swm_pkg::SAMPLE_BITS_DEF;
  localparam int MAX_MISMATCH_REPORTS = 10;
  localparam int RANDOM_ITEMS = 600;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [swm_pkg::SPAN_W-1:0] cfg_window_span;
  logic                       in_valid;
  logic                       in_stall;
  sample_t                    in_sample;
  logic                       out_valid;
  logic                       out_stall;
  sample_t                    out_median;

  // Predictor state: window in arrival order and in ascending order
  sample_t                    arrival_q[$];
  sample_t                    ordered_q[$];
  logic [swm_pkg::SPAN_W-1:0] span_shadow;

  // Medians still owed by the block, oldest first
  sample_t           median_q[$];

  int      mismatches;
  bit      quiet;
  sample_t last_sample;

  sliding_window_median_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_window_span (cfg_window_span),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_median      (out_median)
  );

  always #6 clk = ~clk;

  // Per-beat pause length; quiet phases run back to back
  function automatic int draw_pause();
    if (quiet) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Mix of full-range, clustered (duplicates), extreme and drifting values
  function automatic sample_t next_sample();
    sample_t v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = sample_t'($urandom);
      4, 5:       v = sample_t'($signed($urandom_range(0, 8)) - 4);
      6:          v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      default:    v = last_sample + sample_t'($signed($urandom_range(0, 64)) - 32);
    endcase
    last_sample = v;
    return v;
  endfunction

  // Window update for one accepted sample; returns 1 and the median once full
  function automatic bit advance_window(input sample_t v, output sample_t median);
    int pos;
    sample_t oldest;
    pos = 0;
    while (pos < ordered_q.size() && ordered_q[pos] < v) pos++;
    ordered_q.insert(pos, v);
    arrival_q.insert(arrival_q.size(), v);
    if (arrival_q.size() < int'(span_shadow) + 1) return 0;
    median = ordered_q[span_shadow / 2];
    oldest = arrival_q.pop_front();
    pos = 0;
    while (pos + 1 < ordered_q.size() && ordered_q[pos] != oldest) pos++;
    ordered_q.delete(pos);
    return 1;
  endfunction

  // Monitor: config writes, result check, then prediction for input beats
  always @(posedge clk) begin
    sample_t predicted;
    sample_t owed;
    if (!rst_n) begin
      arrival_q.delete();
      ordered_q.delete();
      span_shadow = swm_pkg::SPAN_RESET;
    end else begin
      if (cfg_we) begin
        span_shadow = cfg_window_span;
        arrival_q.delete();
        ordered_q.delete();
      end
      if (out_valid && !out_stall) begin
        if (median_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_MISMATCH_REPORTS)
            $display("%0t: unexpected result beat, median %0d", $realtime, out_median);
        end else begin
          owed = median_q.pop_front();
          if (out_median !== owed) begin
            mismatches++;
            if (mismatches <= MAX_MISMATCH_REPORTS)
              $display("%0t: median mismatch, expected %0d, got %0d",
                       $realtime, owed, out_median);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (advance_window(in_sample, predicted))
          median_q.insert(median_q.size(), predicted);
      end
    end
  end

  // Result side back-pressure
  always begin
    int n;
    n = draw_pause();
    if (n > 0) begin
      out_stall <= 1'b1;
      repeat (n) @(posedge clk);
    end
    out_stall <= 1'b0;
    do @(posedge clk); while (!(out_valid && rst_n));
  end

  // One input beat; valid stays high after acceptance unless a gap follows
  task automatic send_sample(input sample_t v);
    int gap;
    gap = draw_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Drain, let fill-only beats settle, then write the span register
  task automatic set_span(input logic [swm_pkg::SPAN_W-1:0] span);
    in_valid <= 1'b0;
    @(posedge clk);
    while (median_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we          <= 1'b1;
    cfg_window_span <= span;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reset span, field extremes and alternating bit patterns
  task automatic test_reset_span_extremes();
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(sample_t'(0));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(sample_t'(16'h5555));
    send_sample(sample_t'(16'hAAAA));
  endtask

  // A span write while the window holds samples must empty it
  task automatic test_span_change_clears();
    set_span(swm_pkg::SPAN_W'(2));
    send_sample(sample_t'(100));
    send_sample(sample_t'(-100));
    send_sample(sample_t'(50));
    send_sample(sample_t'(-50));
  endtask

  // Span zero: each sample is its own median
  task automatic test_span_zero();
    set_span(swm_pkg::SPAN_W'(0));
    send_sample(SAMPLE_MAX);
    send_sample(sample_t'(-7));
    send_sample(SAMPLE_MIN);
  endtask

  // Duplicates in the window, oldest removal among equal entries
  task automatic test_equal_samples();
    set_span(swm_pkg::SPAN_W'(3));
    send_sample(sample_t'(7));
    send_sample(sample_t'(7));
    send_sample(sample_t'(7));
    send_sample(sample_t'(-5));
    send_sample(sample_t'(7));
    send_sample(sample_t'(7));
  endtask

  // Random phases over many spans, largest and smallest first
  task automatic test_random_windows();
    int total;
    int phase;
    int count;
    logic [swm_pkg::SPAN_W-1:0] span;
    total = 0;
    phase = 0;
    while (total < RANDOM_ITEMS) begin
      case (phase)
        0:       span = swm_pkg::SPAN_W'(swm_pkg::SPAN_MAX);
        1:       span = swm_pkg::SPAN_W'(1);
        2:       span = swm_pkg::SPAN_W'(0);
        default: span = ($urandom_range(0, 5) == 0) ? swm_pkg::SPAN_W'(swm_pkg::SPAN_MAX)
                                                    : swm_pkg::SPAN_W'($urandom_range(0, 12));
      endcase
      set_span(span);
      quiet = ($urandom_range(0, 3) == 0);
      count = int'(span) + 1 + $urandom_range(10, 60);
      repeat (count) send_sample(next_sample());
      total += count;
      phase++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_window_span = '0;
    in_valid        = 1'b0;
    in_sample       = '0;
    mismatches      = 0;
    quiet           = 1'b0;
    last_sample     = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_span_extremes();
    test_span_change_clears();
    test_span_zero();
    test_equal_samples();
    test_random_windows();

    // Drain outstanding medians, then watch a little longer for strays
    in_valid <= 1'b0;
    @(posedge clk);
    while (median_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (median_q.size() != 0) begin
      mismatches++;
      $display("%0d medians never arrived", median_q.size());
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sliding_window_median_core.f =====
+incdir+src
src/swm_pkg.sv
src/swm_cell.sv
src/sliding_window_median_core.sv
verif/tb_sliding_window_median_core.sv
